@@ rtl/core/cdab_pkg.sv @@
// shared types, constants and byte tables of the captive dns answer builder
// no dependencies; used by every rtl module of the block

package cdab_pkg;

  // configuration port
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic        RegIpv4  = 1'b0;
  localparam logic        RegTtl   = 1'b1;

  localparam logic [31:0] Ipv4Reset = 32'hC0A8_0401;
  localparam logic [31:0] TtlReset  = 32'd30;

  // query layout
  localparam int unsigned IdBytes    = 2;
  localparam int unsigned HdrBytes   = 12;
  localparam int unsigned CountHiPos = 4;
  localparam int unsigned CountLoPos = 5;
  localparam int unsigned LabelStart = 12;
  localparam logic [2:0]  QtailBytes = 3'd4;

  // answer record
  localparam int unsigned AnsCntW    = 4;
  localparam logic [3:0]  AnsLastIdx = 4'd15;

  typedef enum logic [1:0] {
    PH_FORWARD = 2'd0,
    PH_DONE    = 2'd1,
    PH_FAILED  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    TAIL_NONE    = 2'd0,
    TAIL_ANSWER  = 2'd1,
    TAIL_DISCARD = 2'd2
  } tail_e;

  // work handed from the parser to the emitter for one item
  typedef struct packed {
    logic       fwd_valid;
    logic [7:0] fwd_byte;
    tail_e      tail;
  } job_t;

  typedef struct packed {
    logic [31:0] ipv4;
    logic [31:0] ttl;
  } cfg_t;

  // rewritten header bytes 2 to 11
  function automatic logic [7:0] hdr_byte(input logic [3:0] idx);
    logic [7:0] res;
    unique case (idx)
      4'd2:    res = 8'h81;
      4'd3:    res = 8'h80;
      4'd5:    res = 8'h01;
      4'd7:    res = 8'h01;
      default: res = 8'h00;
    endcase
    return res;
  endfunction

  // 16-byte a record: pointer, type, class, ttl, length, address
  function automatic logic [7:0] answer_byte(input logic [3:0]  idx,
                                             input logic [31:0] ttl,
                                             input logic [31:0] ipv4);
    logic [7:0] res;
    unique case (idx)
      4'd0:    res = 8'hC0;
      4'd1:    res = 8'h0C;
      4'd3:    res = 8'h01;
      4'd5:    res = 8'h01;
      4'd6:    res = ttl[31:24];
      4'd7:    res = ttl[23:16];
      4'd8:    res = ttl[15:8];
      4'd9:    res = ttl[7:0];
      4'd11:   res = 8'h04;
      4'd12:   res = ipv4[31:24];
      4'd13:   res = ipv4[23:16];
      4'd14:   res = ipv4[15:8];
      4'd15:   res = ipv4[7:0];
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

@@ rtl/core/cdab_if.sv @@
// valid/ready stream interfaces for query bytes and reply bytes
// no package dependency

interface cdab_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cdab_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_frame;
  logic       discard;

  modport source (output valid, output out_byte, output end_of_frame, output discard,
                  input ready);
  modport sink   (input valid, input out_byte, input end_of_frame, input discard,
                  output ready);
endinterface

@@ rtl/core/cdab_cfg.sv @@
// apb register file holding the answer address and ttl
// depends on cdab_pkg

module cdab_cfg
  import cdab_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  logic [31:0] ipv4_q, ttl_q;
  logic        wr_en;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  // register writes in the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ipv4_q <= Ipv4Reset;
      ttl_q  <= TtlReset;
    end else if (wr_en) begin
      if (reg_sel == RegIpv4) begin
        ipv4_q <= pwdata;
      end else begin
        ttl_q <= pwdata;
      end
    end
  end

  // read mux
  assign prdata = (reg_sel == RegIpv4) ? ipv4_q : ttl_q;

  assign cfg_o.ipv4 = ipv4_q;
  assign cfg_o.ttl  = ttl_q;

endmodule

@@ rtl/core/cdab_parser.sv @@
// input register and per-frame query walker of the dns answer builder
// depends on cdab_pkg and cdab_in_if

module cdab_parser
  import cdab_pkg::*;
#(
  parameter int unsigned MAX_REQUEST_BYTES = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cdab_in_if.sink   query_i,
  output logic      job_valid_o,
  input  logic      job_ready_i,
  output job_t      job_o
);

  localparam int unsigned PosW = $clog2(MAX_REQUEST_BYTES + 1);
  localparam int unsigned LabW = $clog2(MAX_REQUEST_BYTES + 257);

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       adv;

  // frame state
  logic [PosW-1:0] pos_q, pos_d;
  logic [LabW-1:0] nlab_q, nlab_d;
  logic [2:0]      tleft_q, tleft_d, tleft_dec;
  logic            in_tail_q, in_tail_d;
  logic            cnt_hi_q, cnt_hi_d;
  phase_e          phase_q, phase_d;

  assign adv           = in_valid_q && job_ready_i;
  assign query_i.ready = !in_valid_q || job_ready_i;
  assign job_valid_o   = in_valid_q;
  assign tleft_dec     = tleft_q - 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (query_i.ready) begin
      in_valid_q <= query_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_i.ready && query_i.valid) begin
      in_byte_q <= query_i.data_byte;
      in_last_q <= query_i.last_byte;
    end
  end

  // walk header and question name, decide the frame end
  always_comb begin
    pos_d        = pos_q;
    nlab_d       = nlab_q;
    tleft_d      = tleft_q;
    in_tail_d    = in_tail_q;
    cnt_hi_d     = cnt_hi_q;
    phase_d      = phase_q;
    job_o.fwd_valid = 1'b0;
    job_o.fwd_byte  = in_byte_q;
    job_o.tail      = TAIL_NONE;

    if (pos_q < PosW'(MAX_REQUEST_BYTES)) begin
      pos_d = pos_q + PosW'(1);
      if (phase_q == PH_FORWARD) begin
        if (pos_q < PosW'(HdrBytes)) begin
          if (pos_q == PosW'(CountHiPos)) begin
            cnt_hi_d = (in_byte_q != 8'd0);
          end
          if (pos_q == PosW'(CountLoPos) && !cnt_hi_q && in_byte_q == 8'd0) begin
            phase_d = PH_FAILED;
          end else begin
            job_o.fwd_valid = 1'b1;
            job_o.fwd_byte  = (pos_q < PosW'(IdBytes)) ? in_byte_q : hdr_byte(pos_q[3:0]);
          end
        end else if (in_tail_q) begin
          // type and class bytes after the name terminator
          job_o.fwd_valid = 1'b1;
          tleft_d         = tleft_dec;
          if (tleft_dec == 3'd0) begin
            phase_d = PH_DONE;
          end
        end else begin
          if (LabW'(pos_q) == nlab_q) begin
            if (in_byte_q == 8'd0) begin
              in_tail_d = 1'b1;
              tleft_d   = QtailBytes;
            end else begin
              nlab_d = LabW'(pos_q) + LabW'(in_byte_q) + LabW'(1);
            end
          end
          job_o.fwd_valid = 1'b1;
        end
      end
    end

    // final byte: answer or discard, then back to the frame start
    if (in_last_q) begin
      job_o.tail = (phase_d == PH_DONE) ? TAIL_ANSWER : TAIL_DISCARD;
      pos_d      = '0;
      nlab_d     = LabW'(LabelStart);
      tleft_d    = '0;
      in_tail_d  = 1'b0;
      cnt_hi_d   = 1'b0;
      phase_d    = PH_FORWARD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      nlab_q    <= LabW'(LabelStart);
      tleft_q   <= '0;
      in_tail_q <= 1'b0;
      cnt_hi_q  <= 1'b0;
      phase_q   <= PH_FORWARD;
    end else if (adv) begin
      pos_q     <= pos_d;
      nlab_q    <= nlab_d;
      tleft_q   <= tleft_d;
      in_tail_q <= in_tail_d;
      cnt_hi_q  <= cnt_hi_d;
      phase_q   <= phase_d;
    end
  end

`ifndef ASSERT_OFF
  a_done_after_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DONE |-> in_tail_q)
    else $error("question complete without name terminator");

  a_tleft_in_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tleft_q != 3'd0 |-> in_tail_q)
    else $error("type/class count running outside question tail");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(MAX_REQUEST_BYTES))
    else $error("byte position beyond request limit");
`endif

endmodule

@@ rtl/core/cdab_emitter.sv @@
// result register: forwarded byte, then answer burst or discard marker
// depends on cdab_pkg and cdab_out_if

module cdab_emitter
  import cdab_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  output logic       job_ready_o,
  input  job_t       job_i,
  input  cfg_t       cfg_i,
  cdab_out_if.source reply_o
);

  job_t               job_q;
  logic [AnsCntW-1:0] cnt_q;
  logic               busy;
  logic               last_res;
  logic               hs;
  logic               load;

  assign busy = job_q.fwd_valid || (job_q.tail != TAIL_NONE);
  assign hs   = busy && reply_o.ready;

  // current result is the last one of the held item
  always_comb begin
    if (job_q.fwd_valid) begin
      last_res = (job_q.tail == TAIL_NONE);
    end else begin
      last_res = (job_q.tail == TAIL_DISCARD) ||
                 (job_q.tail == TAIL_ANSWER && cnt_q == AnsLastIdx);
    end
  end

  assign job_ready_o = !busy || (reply_o.ready && last_res);
  assign load        = job_valid_i && job_ready_o;

  // hold and step the item's results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_q <= '{fwd_valid: 1'b0, fwd_byte: 8'd0, tail: TAIL_NONE};
      cnt_q <= '0;
    end else if (load) begin
      job_q <= job_i;
      cnt_q <= '0;
    end else if (hs) begin
      if (job_q.fwd_valid) begin
        job_q.fwd_valid <= 1'b0;
      end else if (job_q.tail == TAIL_ANSWER && cnt_q != AnsLastIdx) begin
        cnt_q <= cnt_q + AnsCntW'(1);
      end else begin
        job_q.tail <= TAIL_NONE;
        cnt_q      <= '0;
      end
    end
  end

  // output payload
  always_comb begin
    reply_o.valid        = busy;
    reply_o.out_byte     = 8'd0;
    reply_o.end_of_frame = 1'b0;
    reply_o.discard      = 1'b0;
    if (job_q.fwd_valid) begin
      reply_o.out_byte = job_q.fwd_byte;
    end else if (job_q.tail == TAIL_ANSWER) begin
      reply_o.out_byte     = answer_byte(cnt_q, cfg_i.ttl, cfg_i.ipv4);
      reply_o.end_of_frame = (cnt_q == AnsLastIdx);
    end else if (job_q.tail == TAIL_DISCARD) begin
      reply_o.end_of_frame = 1'b1;
      reply_o.discard      = 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_only_in_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_q.tail != TAIL_ANSWER |-> cnt_q == '0)
    else $error("answer counter moved outside an answer burst");

  a_idle_after_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hs && reply_o.end_of_frame && !load) |=> !reply_o.valid)
    else $error("results continue after end of frame");

  a_discard_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (reply_o.valid && reply_o.discard) |-> (reply_o.end_of_frame && reply_o.out_byte == 8'd0))
    else $error("malformed discard marker");
`endif

endmodule

@@ rtl/core/captive_dns_answer_builder_unit.sv @@
// Captive-portal DNS answer builder.
// query_i takes one query byte per item with last_byte on the final one;
// reply_o gives the reply bytes cut-through: id bytes pass, header bytes
// 2..11 become flags 8180 / qd 1 / an 1, the question name, terminator and
// type/class pass, later bytes are dropped. On the final byte a 16-byte A
// record follows (end_of_frame on its last byte), or a single discard
// marker if the frame was short, had no question, ended inside it, or if
// its question ran past MAX_REQUEST_BYTES. An accepted byte passes the
// input register, then the result register, before it is offered on
// reply_o. Throughput is one byte per cycle while reply_o.ready is high
// and no answer burst runs; during an answer burst query_i.ready drops
// once the input register is full. When reply_o.ready is low, results hold
// and back-pressure reaches query_i after one buffered item. Configuration
// goes through the APB port (0x0 address, 0x4 ttl). Reset clears the frame
// walker and stream registers; address resets to 192.168.4.1 and ttl to 30.
// depends on cdab_pkg, cdab_if, cdab_cfg, cdab_parser, cdab_emitter

module captive_dns_answer_builder_unit
  import cdab_pkg::*;
#(
  parameter int unsigned MAX_REQUEST_BYTES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  cdab_in_if.sink             query_i,
  cdab_out_if.source          reply_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  cfg_t cfg;
  job_t job;
  logic job_valid;
  logic job_ready;

  cdab_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cdab_parser #(
    .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .query_i     (query_i),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  cdab_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .cfg_i       (cfg),
    .reply_o     (reply_o)
  );

endmodule

@@ tb/tb_captive_dns_answer_builder_unit.sv @@
// self-checking testbench for the captive dns answer builder
// depends on cdab_pkg, cdab_if and the captive_dns_answer_builder_unit rtl
`timescale 1ns / 1ps

module tb_captive_dns_answer_builder_unit;
  import cdab_pkg::*;

  localparam int unsigned MaxQueryBytes = 256;
  localparam int unsigned IdleLimit     = 1000;
  localparam int unsigned DrainCycles   = 6;
  localparam int unsigned LongHold      = 80;
  localparam int unsigned PhaseItems    = 8;

  localparam logic [CfgAddrW-1:0] AddrIpv4 = {RegIpv4, 2'b00};
  localparam logic [CfgAddrW-1:0] AddrTtl  = {RegTtl, 2'b00};

  // rewritten header, byte 0 in the top octet
  localparam logic [95:0] ReplyHdr   = 96'h0000_8180_0001_0001_0000_0000;
  localparam logic [15:0] NamePtr    = 16'hC00C;
  localparam logic [15:0] DnsTypeA   = 16'd1;
  localparam logic [15:0] DnsClassIn = 16'd1;
  localparam logic [15:0] Ipv4Len    = 16'd4;

  typedef struct packed {
    logic [7:0] octet;
    logic       eof;
    logic       disc;
  } reply_t;

  typedef struct packed {
    logic [7:0] octet;
    logic       last;
    logic       fixed;
    reply_t     want;
  } query_row_t;

  typedef enum int unsigned {
    SHAPE_GOOD,
    SHAPE_CUT,
    SHAPE_NO_COUNT,
    SHAPE_NOISE,
    SHAPE_OVERSIZE,
    SHAPE_DEEP_NAME
  } shape_e;

  logic clk;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata, prdata;

  cdab_in_if  query_ch ();
  cdab_out_if reply_ch ();

  captive_dns_answer_builder_unit #(
    .MAX_REQUEST_BYTES(MaxQueryBytes)
  ) uut (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .query_i (query_ch),
    .reply_o (reply_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state and its copy of the registers
  logic [31:0]  cfg_ipv4, cfg_ttl;
  int unsigned  q_pos, label_at;
  logic [2:0]   qtail_left;
  logic         in_qtail, qdcount_hi;
  phase_e       walk_phase;

  reply_t       reply_bytes_due [$];
  logic [7:0]   query_bytes [$];
  query_row_t   directed_rows [26];

  int unsigned  errors;
  int unsigned  idle_cycles;
  int unsigned  hold_len;
  bit           calm;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void restart_walk();
    q_pos      = 0;
    label_at   = LabelStart;
    qtail_left = '0;
    in_qtail   = 1'b0;
    qdcount_hi = 1'b0;
    walk_phase = PH_FORWARD;
  endfunction

  function automatic void queue_reply(input logic [7:0] v, input logic eof, input logic disc,
                                      input bit keep);
    reply_t r;
    r.octet = v;
    r.eof   = eof;
    r.disc  = disc;
    if (keep) reply_bytes_due.push_back(r);
  endfunction

  // works out the reply bytes caused by one query byte
  function automatic void build_reply_bytes(input logic [7:0] b, input logic last,
                                            input bit keep);
    int unsigned  p;
    logic [127:0] rec;
    if (q_pos < MaxQueryBytes) begin
      p = q_pos;
      q_pos++;
      if (walk_phase == PH_FORWARD) begin
        if (p < HdrBytes) begin
          if (p == CountHiPos) qdcount_hi = (b != 8'h00);
          if (p == CountLoPos && !qdcount_hi && b == 8'h00) begin
            walk_phase = PH_FAILED;
          end else begin
            queue_reply((p < IdBytes) ? b : ReplyHdr[95 - 8*p -: 8], 1'b0, 1'b0, keep);
          end
        end else if (in_qtail) begin
          queue_reply(b, 1'b0, 1'b0, keep);
          qtail_left = qtail_left - 3'd1;
          if (qtail_left == '0) walk_phase = PH_DONE;
        end else begin
          // label length bytes steer the walk through the name
          if (p == label_at) begin
            if (b == 8'h00) begin
              in_qtail   = 1'b1;
              qtail_left = QtailBytes;
            end else begin
              label_at = p + b + 1;
            end
          end
          queue_reply(b, 1'b0, 1'b0, keep);
        end
      end
    end
    if (last) begin
      if (walk_phase == PH_DONE) begin
        rec = {NamePtr, DnsTypeA, DnsClassIn, cfg_ttl, Ipv4Len, cfg_ipv4};
        for (int i = 15; i >= 0; i--) queue_reply(rec[8*i +: 8], i == 0, 1'b0, keep);
      end else begin
        queue_reply(8'h00, 1'b1, 1'b1, keep);
      end
      restart_walk();
    end
  endfunction

  // offer one query item, optionally after letting the reply side drain
  task automatic send_query_byte(input logic [7:0] b, input logic last, input bit drain,
                                 input bit fixed, input reply_t want);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0 || drain) query_ch.valid <= 1'b0;
    if (drain) begin
      wait (reply_bytes_due.size() == 0);
      @(posedge clk);
    end
    repeat (gap) @(posedge clk);
    query_ch.valid     <= 1'b1;
    query_ch.data_byte <= b;
    query_ch.last_byte <= last;
    do @(posedge clk); while (!(query_ch.valid && query_ch.ready));
    build_reply_bytes(b, last, !fixed);
    if (fixed) reply_bytes_due.push_back(want);
  endtask

  task automatic send_query();
    int unsigned n;
    n = query_bytes.size();
    for (int unsigned i = 0; i < n; i++) begin
      send_query_byte(query_bytes[i], i == n - 1, !calm && $urandom_range(0, 39) == 0,
                      1'b0, '0);
    end
  endtask

  // assembles one query datagram of the given shape
  function automatic void make_query(input shape_e shape);
    int unsigned nlab, len, cut, stop;
    logic [7:0]  hi;
    query_bytes.delete();
    repeat (4) query_bytes.push_back(8'($urandom_range(0, 255)));
    hi = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
    query_bytes.push_back(hi);
    query_bytes.push_back((hi == 8'h00) ? 8'($urandom_range(1, 255)) :
                                          8'($urandom_range(0, 255)));
    repeat (6) query_bytes.push_back(8'($urandom_range(0, 255)));
    if (shape == SHAPE_DEEP_NAME) begin
      // name keeps going past the size limit
      repeat (4) begin
        query_bytes.push_back(8'd63);
        repeat (63) query_bytes.push_back(8'($urandom_range(0, 255)));
      end
      repeat ($urandom_range(1, 4)) query_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    nlab = $urandom_range(0, 3);
    repeat (nlab) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 63) : $urandom_range(1, 10);
      query_bytes.push_back(8'(len));
      repeat (len) query_bytes.push_back(8'($urandom_range(0, 255)));
    end
    query_bytes.push_back(8'h00);
    repeat (4) query_bytes.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) query_bytes.push_back(8'($urandom_range(0, 255)));
    end
    case (shape)
      SHAPE_CUT: begin
        cut = $urandom_range(1, query_bytes.size() - 1);
        while (query_bytes.size() > cut) void'(query_bytes.pop_back());
      end
      SHAPE_NO_COUNT: begin
        query_bytes[CountHiPos] = 8'h00;
        query_bytes[CountLoPos] = 8'h00;
      end
      SHAPE_NOISE: begin
        query_bytes.delete();
        repeat ($urandom_range(1, 40)) query_bytes.push_back(8'($urandom_range(0, 255)));
      end
      SHAPE_OVERSIZE: begin
        stop = MaxQueryBytes + $urandom_range(1, 8);
        while (query_bytes.size() < stop) query_bytes.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
  endfunction

  task automatic run_random_queries(input int unsigned budget);
    int unsigned sent, pick;
    shape_e      shape;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6)      shape = SHAPE_GOOD;
      else if (pick == 7) shape = SHAPE_CUT;
      else if (pick == 8) shape = SHAPE_NO_COUNT;
      else                shape = SHAPE_NOISE;
      make_query(shape);
      sent += query_bytes.size();
      send_query();
    end
  endtask

  // stop offering and let the block run dry before touching registers
  task automatic drain_block();
    query_ch.valid <= 1'b0;
    wait (reply_bytes_due.size() == 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // apb write, then read back the same register
  task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == AddrIpv4) cfg_ipv4 = value;
    else                  cfg_ttl  = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== value) begin
      flag_error($sformatf("register %0h reads %0h, wrote %0h", addr, prdata, value));
    end
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // reply side: per-item stall, plus a long hold when asked
  initial begin
    int unsigned gap;
    bit          held;
    held = 1'b0;
    reply_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_len > 0 && !held) begin
        reply_ch.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        held = 1'b1;
      end
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        reply_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      reply_ch.ready <= 1'b1;
      do @(posedge clk); while (!(reply_ch.valid && reply_ch.ready));
    end
  end

  // compare each reply item with the oldest one due
  always @(posedge clk) begin : check_reply
    reply_t got, want;
    if (rst_ni && reply_ch.valid && reply_ch.ready) begin
      got.octet = reply_ch.out_byte;
      got.eof   = reply_ch.end_of_frame;
      got.disc  = reply_ch.discard;
      if (reply_bytes_due.size() == 0) begin
        flag_error($sformatf("unexpected reply item %0h eof %0b discard %0b",
                             got.octet, got.eof, got.disc));
      end else begin
        want = reply_bytes_due.pop_front();
        if (got.octet !== want.octet)
          flag_error($sformatf("out_byte %0h, want %0h", got.octet, want.octet));
        if (got.eof !== want.eof)
          flag_error($sformatf("end_of_frame %0b, want %0b", got.eof, want.eof));
        if (got.disc !== want.disc)
          flag_error($sformatf("discard %0b, want %0b", got.disc, want.disc));
      end
    end
  end

  // watchdog on cycles with no traffic anywhere
  always @(posedge clk) begin
    if (!rst_ni || psel || (query_ch.valid && query_ch.ready) ||
        (reply_ch.valid && reply_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no progress for %0d cycles", IdleLimit);
      $display("tb_captive_dns_answer_builder_unit NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    errors      = 0;
    hold_len    = 0;
    calm        = 1'b0;
    rst_ni             <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    query_ch.valid     <= 1'b0;
    query_ch.data_byte <= '0;
    query_ch.last_byte <= 1'b0;
    cfg_ipv4 = Ipv4Reset;
    cfg_ttl  = TtlReset;
    restart_walk();

    // directed: short frame, zero question count, minimal full query
    directed_rows = '{
      '{8'hFF, 1'b1, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}},
      '{8'hFF, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0}, '{8'h01, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, '0}, '{8'h7F, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b1, 1'b0, '0}
    };

    repeat (2) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_query_byte(directed_rows[i].octet, directed_rows[i].last, 1'b0,
                      directed_rows[i].fixed, directed_rows[i].want);
    end
    drain_block();

    // all-zero registers
    write_reg(AddrIpv4, 32'h0000_0000);
    write_reg(AddrTtl, 32'h0000_0000);
    run_random_queries(PhaseItems);
    drain_block();

    // all-ones registers, no idling, with a long reply stall
    write_reg(AddrIpv4, 32'hFFFF_FFFF);
    write_reg(AddrTtl, 32'hFFFF_FFFF);
    calm     = 1'b1;
    hold_len = LongHold;
    run_random_queries(PhaseItems);
    calm = 1'b0;
    drain_block();

    // random registers, one oversized query
    write_reg(AddrIpv4, $urandom());
    write_reg(AddrTtl, $urandom());
    make_query(($urandom_range(0, 1) == 0) ? SHAPE_OVERSIZE : SHAPE_DEEP_NAME);
    send_query();
    drain_block();

    write_reg(AddrTtl, $urandom());
    write_reg(AddrIpv4, $urandom());
    run_random_queries(PhaseItems);
    drain_block();

    if (errors == 0) begin
      $display("tb_captive_dns_answer_builder_unit OK");
    end else begin
      $display("tb_captive_dns_answer_builder_unit NOT OK");
    end
    $finish;
  end

endmodule
